@@ rtl/core/jsi_pkg.sv @@
// Shared types, constants and codes of the joystick setpoint integrator.
`default_nettype none

package jsi_pkg;

  localparam int unsigned AXES          = 6;
  localparam int unsigned AXIS_W        = 16;
  localparam int unsigned GAIN_W        = 24;
  localparam int unsigned OUT_W         = 32;
  localparam int unsigned ACC_WIDTH_DEF = 32;
  localparam int unsigned AXIS_SHIFT    = 23;
  localparam int unsigned RATE_SHIFT    = 24;

  localparam int unsigned AXIS_IDX_W = 3;
  localparam int unsigned ENTRIES    = 2 * AXES;
  localparam int unsigned ADDR_W     = 4;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = GAIN_W;

  localparam int unsigned IN_TDATA_W  = AXES * AXIS_W;
  localparam int unsigned IN_TUSER_W  = 3;
  localparam int unsigned OUT_TDATA_W = AXES * OUT_W;
  localparam int unsigned OUT_TUSER_W = 4;

  localparam int unsigned BTN_MODE  = 0;
  localparam int unsigned BTN_RESET = 1;
  localparam int unsigned BTN_PAUSE = 2;

  localparam logic [AXIS_IDX_W-1:0] AXIS_Z    = 3'd2;
  localparam logic [AXIS_IDX_W-1:0] AXIS_LAST = 3'd5;

  localparam logic [GAIN_W-1:0] LIN_POS_RST = 24'd838861;
  localparam logic [GAIN_W-1:0] ANG_POS_RST = 24'd73201;
  localparam logic [GAIN_W-1:0] LIN_VEL_RST = 24'd167772;
  localparam logic [GAIN_W-1:0] ANG_VEL_RST = 24'd14640;

  typedef logic [GAIN_W-1:0]        gain_t;
  typedef logic signed [AXIS_W-1:0] axis_t;
  typedef logic [OUT_W-1:0]         pose_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LIN_POS,
    REG_ANG_POS,
    REG_LIN_VEL,
    REG_ANG_VEL
  } cfg_reg_e;

  typedef enum logic [1:0] {
    EV_NONE,
    EV_PAUSE,
    EV_RESUME
  } pause_ev_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_VUPD,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_PUPD,
    ST_DONE
  } state_e;

  typedef enum logic [2:0] {
    MS_NONE,
    MS_AXIS,
    MS_RATE,
    MS_LO,
    MS_HI,
    MS_POSE
  } mac_step_e;

  typedef struct packed {
    mac_step_e step;
    logic      vel;
    logic      neg;
  } mac_ctl_t;

endpackage

`default_nettype wire

@@ rtl/core/jsi_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module jsi_ram #(
  parameter int unsigned WIDTH = jsi_pkg::ACC_WIDTH_DEF,
  parameter int unsigned DEPTH = jsi_pkg::ENTRIES,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ rtl/core/jsi_mac.sv @@
// Shared multiplier, rounding and saturating accumulate datapath.
`default_nettype none

module jsi_mac #(
  parameter int unsigned ACC_WIDTH = jsi_pkg::ACC_WIDTH_DEF
) (
  input  wire logic                 clk_i,
  input  wire jsi_pkg::mac_ctl_t    ctl_i,
  input  wire jsi_pkg::axis_t       axis_i,
  input  wire jsi_pkg::gain_t       pos_gain_i,
  input  wire jsi_pkg::gain_t       vel_gain_i,
  input  wire logic [ACC_WIDTH-1:0] rdata_i,
  input  wire logic                 rvalid_i,
  output logic      [ACC_WIDTH-1:0] wdata_o,
  output jsi_pkg::pose_t            pose_o
);

  import jsi_pkg::*;

  localparam int unsigned SUM_W  = ACC_WIDTH + 2;
  localparam int unsigned NEG_W  = ACC_WIDTH + 1;
  localparam int unsigned HI_W   = NEG_W - RATE_SHIFT;
  localparam int unsigned MUL_W  = (HI_W > GAIN_W + 1) ? HI_W : GAIN_W + 1;
  localparam int unsigned PROD_W = 2 * MUL_W;
  localparam int unsigned EXT_W  = (ACC_WIDTH > OUT_W) ? ACC_WIDTH : OUT_W;

  localparam logic signed [PROD_W-1:0] HALF_AXIS = PROD_W'(64'd1 << (AXIS_SHIFT - 1));
  localparam logic signed [PROD_W-1:0] HALF_RATE = PROD_W'(64'd1 << (RATE_SHIFT - 1));

  function automatic logic [ACC_WIDTH-1:0] sat_acc(input logic signed [SUM_W-1:0] s);
    logic ovf;
    ovf = (s[SUM_W-1:ACC_WIDTH-1] != {(SUM_W - ACC_WIDTH + 1){s[SUM_W-1]}});
    if (!ovf) begin
      return s[ACC_WIDTH-1:0];
    end else if (s[SUM_W-1]) begin
      return {1'b1, {(ACC_WIDTH - 1){1'b0}}};
    end else begin
      return {1'b0, {(ACC_WIDTH - 1){1'b1}}};
    end
  endfunction

  logic signed [MUL_W-1:0]    mul_a;
  logic signed [MUL_W-1:0]    mul_b;
  logic signed [PROD_W-1:0]   prod_q;
  logic signed [AXIS_W:0]     ax_ext;
  logic signed [AXIS_W:0]     ax_op;
  gain_t                      gain_sel;
  logic signed [PROD_W-1:0]   axis_sh;
  logic signed [PROD_W-1:0]   lo_sh;
  logic signed [SUM_W-1:0]    axis_term;
  logic        [GAIN_W:0]     lo_term_q;
  logic signed [ACC_WIDTH-1:0] acc_in;
  logic signed [SUM_W-1:0]    acc_ext;
  logic        [ACC_WIDTH-1:0] rate_new;
  logic signed [NEG_W-1:0]    rate_ext;
  logic signed [NEG_W-1:0]    rneg_d;
  logic signed [NEG_W-1:0]    rneg_q;
  logic signed [SUM_W-1:0]    hi_term;
  logic signed [SUM_W-1:0]    delta;
  logic        [ACC_WIDTH-1:0] pose_new;
  logic signed [EXT_W-1:0]    pose_ext;
  logic                       pose_ovf;

  assign ax_ext   = (AXIS_W + 1)'(axis_i);
  assign ax_op    = ctl_i.neg ? -ax_ext : ax_ext;
  assign gain_sel = (ctl_i.step == MS_AXIS && ctl_i.vel) ? vel_gain_i : pos_gain_i;
  assign mul_b    = MUL_W'(gain_sel);

  always_comb begin
    case (ctl_i.step)
      MS_AXIS: mul_a = MUL_W'(ax_op);
      MS_LO:   mul_a = MUL_W'(rneg_q[RATE_SHIFT-1:0]);
      MS_HI:   mul_a = MUL_W'($signed(rneg_q[NEG_W-1:RATE_SHIFT]));
      default: mul_a = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (ctl_i.step == MS_RATE) begin
      rneg_q <= rneg_d;
    end
    if (ctl_i.step == MS_HI) begin
      lo_term_q <= lo_sh[GAIN_W:0];
    end
  end

  assign axis_sh   = (prod_q + HALF_AXIS) >>> AXIS_SHIFT;
  assign lo_sh     = (prod_q + HALF_RATE) >>> RATE_SHIFT;
  assign axis_term = axis_sh[SUM_W-1:0];

  assign acc_in  = rvalid_i ? rdata_i : '0;
  assign acc_ext = SUM_W'(acc_in);

  assign rate_new = sat_acc(acc_ext + axis_term);
  assign rate_ext = NEG_W'($signed(rate_new));
  assign rneg_d   = ctl_i.neg ? -rate_ext : rate_ext;

  assign hi_term  = prod_q[SUM_W-1:0];
  assign delta    = ctl_i.vel ? hi_term + SUM_W'(lo_term_q) : axis_term;
  assign pose_new = sat_acc(acc_ext + delta);

  assign wdata_o = (ctl_i.step == MS_RATE) ? rate_new : pose_new;

  assign pose_ext = EXT_W'($signed(pose_new));
  assign pose_ovf = (pose_ext[EXT_W-1:OUT_W-1] != {(EXT_W - OUT_W + 1){pose_ext[EXT_W-1]}});

  always_comb begin
    if (!pose_ovf) begin
      pose_o = pose_ext[OUT_W-1:0];
    end else if (pose_ext[EXT_W-1]) begin
      pose_o = {1'b1, {(OUT_W - 1){1'b0}}};
    end else begin
      pose_o = {1'b0, {(OUT_W - 1){1'b1}}};
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/jsi_ctrl.sv @@
// Sequencer, button logic, gain registers and stream handshakes.
`default_nettype none

module jsi_ctrl (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                s_tvalid_i,
  output logic                                     s_tready_o,
  input  wire logic [jsi_pkg::IN_TDATA_W-1:0]      s_tdata_i,
  input  wire logic [jsi_pkg::IN_TUSER_W-1:0]      s_tuser_i,
  output logic                                     m_tvalid_o,
  input  wire logic                                m_tready_i,
  output logic      [jsi_pkg::OUT_TDATA_W-1:0]     m_tdata_o,
  output logic      [jsi_pkg::OUT_TUSER_W-1:0]     m_tuser_o,
  input  wire logic                                cfg_we_i,
  input  wire logic [jsi_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire logic [jsi_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  output jsi_pkg::mac_ctl_t                        mac_ctl_o,
  output jsi_pkg::axis_t                           axis_o,
  output jsi_pkg::gain_t                           pos_gain_o,
  output jsi_pkg::gain_t                           vel_gain_o,
  output logic                                     rvalid_o,
  input  wire jsi_pkg::pose_t                      pose_i,
  output logic                                     ram_we_o,
  output logic      [jsi_pkg::ADDR_W-1:0]          ram_waddr_o,
  output logic                                     ram_re_o,
  output logic      [jsi_pkg::ADDR_W-1:0]          ram_raddr_o
);

  import jsi_pkg::*;

  state_e                        state_q, state_d;
  logic [AXIS_IDX_W-1:0]         axis_q, axis_d;
  logic [AXES-1:0][AXIS_W-1:0]   in_axes_q;
  logic [IN_TUSER_W-1:0]         in_btn_q;
  gain_t                         lin_pos_q, ang_pos_q, lin_vel_q, ang_vel_q;
  logic                          mode_q, phase_q, prev_mode_q, prev_reset_q, prev_pause_q;
  logic                          paused_q;
  logic [ENTRIES-1:0]            valid_q;
  logic                          rvalid_q;
  pose_t                         stage_q [AXES];
  logic [AXES-1:0][OUT_W-1:0]    out_pose_q;
  logic                          out_valid_q, out_mode_q, out_paused_q;
  pause_ev_e                     out_event_q;
  logic                          out_free, commit, accept;
  logic                          reset_rel, pause_rel, mode_rel;
  pause_ev_e                     event_d;
  logic [ADDR_W-1:0]             pose_addr, rate_addr;
  logic                          lin_axis;

  assign out_free  = !out_valid_q || m_tready_i;
  assign commit    = (state_q == ST_DONE) && out_free;
  assign accept    = s_tvalid_i && s_tready_o;
  assign reset_rel = !in_btn_q[BTN_RESET] && prev_reset_q;
  assign pause_rel = !in_btn_q[BTN_PAUSE] && prev_pause_q;
  assign mode_rel  = !in_btn_q[BTN_MODE] && prev_mode_q;
  assign event_d   = !pause_rel ? EV_NONE : (paused_q ? EV_RESUME : EV_PAUSE);
  assign pose_addr = ADDR_W'(axis_q);
  assign rate_addr = ADDR_W'(axis_q) + ADDR_W'(AXES);
  assign lin_axis  = (axis_q <= AXIS_Z);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (s_tvalid_i) state_d = ST_RD;
      ST_RD:     state_d = mode_q ? ST_VUPD : ST_PUPD;
      ST_VUPD:   state_d = ST_MUL_LO;
      ST_MUL_LO: state_d = ST_MUL_HI;
      ST_MUL_HI: state_d = ST_PUPD;
      ST_PUPD:   state_d = (axis_q == AXIS_LAST) ? ST_DONE : ST_RD;
      ST_DONE:   if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready_o     = 1'b0;
    axis_d         = axis_q;
    mac_ctl_o.step = MS_NONE;
    mac_ctl_o.vel  = mode_q;
    mac_ctl_o.neg  = (axis_q == AXIS_Z) && ((state_q == ST_VUPD) || !mode_q);
    ram_we_o       = 1'b0;
    ram_waddr_o    = pose_addr;
    ram_re_o       = 1'b0;
    ram_raddr_o    = pose_addr;
    unique case (state_q)
      ST_IDLE: begin
        s_tready_o = 1'b1;
        axis_d     = '0;
      end
      ST_RD: begin
        mac_ctl_o.step = MS_AXIS;
        ram_re_o       = 1'b1;
        ram_raddr_o    = mode_q ? rate_addr : pose_addr;
      end
      ST_VUPD: begin
        mac_ctl_o.step = MS_RATE;
        ram_we_o       = 1'b1;
        ram_waddr_o    = rate_addr;
        ram_re_o       = 1'b1;
      end
      ST_MUL_LO: begin
        mac_ctl_o.step = MS_LO;
      end
      ST_MUL_HI: begin
        mac_ctl_o.step = MS_HI;
      end
      ST_PUPD: begin
        mac_ctl_o.step = MS_POSE;
        ram_we_o       = 1'b1;
        axis_d         = axis_q + AXIS_IDX_W'(1);
      end
      ST_DONE: begin
        mac_ctl_o.step = MS_NONE;
      end
      default: begin
        mac_ctl_o.step = MS_NONE;
      end
    endcase
  end

  assign axis_o     = in_axes_q[axis_q];
  assign pos_gain_o = lin_axis ? lin_pos_q : ang_pos_q;
  assign vel_gain_o = lin_axis ? lin_vel_q : ang_vel_q;
  assign rvalid_o   = rvalid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      axis_q       <= '0;
      lin_pos_q    <= LIN_POS_RST;
      ang_pos_q    <= ANG_POS_RST;
      lin_vel_q    <= LIN_VEL_RST;
      ang_vel_q    <= ANG_VEL_RST;
      mode_q       <= 1'b0;
      phase_q      <= 1'b1;
      prev_mode_q  <= 1'b1;
      prev_reset_q <= 1'b1;
      prev_pause_q <= 1'b0;
      paused_q     <= 1'b1;
      valid_q      <= '0;
      rvalid_q     <= 1'b0;
      out_valid_q  <= 1'b0;
      out_mode_q   <= 1'b0;
      out_paused_q <= 1'b0;
      out_event_q  <= EV_NONE;
    end else begin
      state_q <= state_d;
      axis_q  <= axis_d;
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_idx_i))
          REG_LIN_POS: lin_pos_q <= cfg_wdata_i;
          REG_ANG_POS: ang_pos_q <= cfg_wdata_i;
          REG_LIN_VEL: lin_vel_q <= cfg_wdata_i;
          REG_ANG_VEL: ang_vel_q <= cfg_wdata_i;
          default:     lin_pos_q <= lin_pos_q;
        endcase
      end
      if (ram_re_o) begin
        rvalid_q <= valid_q[ram_raddr_o];
      end
      if (ram_we_o) begin
        valid_q[ram_waddr_o] <= 1'b1;
      end
      if (commit) begin
        if (reset_rel) begin
          valid_q <= '0;
        end
        if (pause_rel) begin
          paused_q <= !paused_q;
        end
        if (mode_rel) begin
          phase_q <= !phase_q;
          mode_q  <= !phase_q;
        end
        prev_mode_q  <= in_btn_q[BTN_MODE];
        prev_reset_q <= in_btn_q[BTN_RESET];
        prev_pause_q <= in_btn_q[BTN_PAUSE];
        out_valid_q  <= 1'b1;
        out_mode_q   <= mode_rel ? !phase_q : mode_q;
        out_paused_q <= pause_rel ? !paused_q : paused_q;
        out_event_q  <= event_d;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_axes_q <= s_tdata_i;
      in_btn_q  <= s_tuser_i;
    end
    if (state_q == ST_PUPD) begin
      stage_q[axis_q] <= pose_i;
    end
    if (commit) begin
      for (int i = 0; i < AXES; i++) begin
        out_pose_q[i] <= reset_rel ? '0 : stage_q[i];
      end
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_pose_q;
  assign m_tuser_o  = {out_event_q, out_paused_q, out_mode_q};

  a_idle_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !ram_we_o)
    else $error("Accumulator memory written while no sample is in work.");

  a_no_same_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we_o && ram_re_o) |-> (ram_waddr_o != ram_raddr_o))
    else $error("Read and write of the same accumulator entry in one cycle.");

  a_accept_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_RD && axis_q == '0))
    else $error("Accepted beat did not start at the first axis.");

  a_commit_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> out_valid_q)
    else $error("Finished sample did not reach the output register.");

  a_reset_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit && reset_rel) |=> (valid_q == '0))
    else $error("Reset button release left accumulator entries valid.");

endmodule

`default_nettype wire

@@ rtl/core/joystick_setpoint_integrator.sv @@
// Top level of the joystick setpoint integrator.
//
//   Channel  Direction  Signals                    Contents
//   s_*      in         tvalid tready tdata tuser  one joystick sample per beat
//   m_*      out        tvalid tready tdata tuser  pose and status per sample
//   cfg_*    in         we idx wdata               gain register writes
//
// Each axis of a sample passes the read and pose update steps in position mode,
// and also rate update, low and high multiply steps in velocity mode, through
// the single shared multiplier and one-read, one-write accumulator memory.
// Reset clears the accumulators at once through per-entry valid bits.
// A result waits in the output register; the next beat is taken meanwhile,
// and the sequencer holds in its last step only while that register is full.
`default_nettype none

module joystick_setpoint_integrator #(
  parameter int unsigned ACC_WIDTH = jsi_pkg::ACC_WIDTH_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_tvalid_i,
  output logic                                  s_tready_o,
  // axis_x, axis_y, axis_z, axis_roll, axis_pitch, axis_yaw (16 bits each).
  input  wire logic [jsi_pkg::IN_TDATA_W-1:0]   s_tdata_i,
  // btn_mode, btn_reset, btn_pause.
  input  wire logic [jsi_pkg::IN_TUSER_W-1:0]   s_tuser_i,
  output logic                                  m_tvalid_o,
  input  wire logic                             m_tready_i,
  // pos_x, pos_y, pos_z, att_roll, att_pitch, att_yaw (32 bits each).
  output logic      [jsi_pkg::OUT_TDATA_W-1:0]  m_tdata_o,
  // motion_mode_out, paused_out, pause_event (2 bits).
  output logic      [jsi_pkg::OUT_TUSER_W-1:0]  m_tuser_o,
  input  wire logic                             cfg_we_i,
  input  wire logic [jsi_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [jsi_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);

  import jsi_pkg::*;

  mac_ctl_t               mac_ctl;
  axis_t                  axis;
  gain_t                  pos_gain, vel_gain;
  logic                   rvalid;
  pose_t                  pose;
  logic                   ram_we, ram_re;
  logic [ADDR_W-1:0]      ram_waddr, ram_raddr;
  logic [ACC_WIDTH-1:0]   ram_wdata, ram_rdata;

  jsi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_tvalid_i),
    .s_tready_o  (s_tready_o),
    .s_tdata_i   (s_tdata_i),
    .s_tuser_i   (s_tuser_i),
    .m_tvalid_o  (m_tvalid_o),
    .m_tready_i  (m_tready_i),
    .m_tdata_o   (m_tdata_o),
    .m_tuser_o   (m_tuser_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .mac_ctl_o   (mac_ctl),
    .axis_o      (axis),
    .pos_gain_o  (pos_gain),
    .vel_gain_o  (vel_gain),
    .rvalid_o    (rvalid),
    .pose_i      (pose),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr)
  );

  jsi_mac #(
    .ACC_WIDTH (ACC_WIDTH)
  ) u_mac (
    .clk_i      (clk_i),
    .ctl_i      (mac_ctl),
    .axis_i     (axis),
    .pos_gain_i (pos_gain),
    .vel_gain_i (vel_gain),
    .rdata_i    (ram_rdata),
    .rvalid_i   (rvalid),
    .wdata_o    (ram_wdata),
    .pose_o     (pose)
  );

  jsi_ram #(
    .WIDTH (ACC_WIDTH),
    .DEPTH (ENTRIES)
  ) u_acc_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

`default_nettype wire
